@@ sv/kcv_pkg.sv @@
// Shared types, constants and saturating arithmetic for the 2D constant-velocity tracker.
`default_nettype none
package kcv_pkg;

	localparam int DATA_W_DEF = 32;
	localparam int COV_W_DEF  = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 47;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PN_POS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PN_CROSS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PN_VEL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MN_X        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MN_Y        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VEL_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VEL_Y = 3'd7;

	localparam logic [31:0] RST_TIME_STEP   = 32'd2684355;
	localparam logic [46:0] RST_PN_POS      = 47'd24739;
	localparam logic [46:0] RST_PN_CROSS    = 47'd4947802;
	localparam logic [46:0] RST_PN_VEL      = 47'd989560465;
	localparam logic [46:0] RST_MN_X       = 47'd1099511627776;
	localparam logic [46:0] RST_MN_Y       = 47'd879609302221;
	localparam logic [31:0] RST_START_VEL_X = 32'd655360;
	localparam logic [31:0] RST_START_VEL_Y = 32'd327680;

	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [4:0] {
		ST_IDLE, ST_M_XP, ST_W_XP, ST_M_C1, ST_W_C1, ST_M_PP, ST_W_PP,
		ST_D_K0, ST_W_K0, ST_D_K1, ST_W_K1, ST_M_E0, ST_W_POS, ST_M_E1,
		ST_W_VEL, ST_M_CP, ST_W_CP, ST_M_CC, ST_W_CC, ST_M_CV, ST_W_CV, ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_M_XP, OP_W_XP, OP_M_C1, OP_W_C1, OP_M_PP, OP_W_PP,
		OP_D_K0, OP_W_K0, OP_D_K1, OP_W_K1, OP_M_E0, OP_W_POS, OP_M_E1, OP_W_VEL,
		OP_M_CP, OP_W_CP, OP_M_CC, OP_W_CC, OP_M_CV, OP_W_CV, OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic ax;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic out_full;
	} sts_t;

	typedef struct packed {
		logic        f;
		logic [63:0] v;
	} sat_t;

	function automatic sat_t usadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] r;
		sat_t        o;
		r = {1'b0, a} + {1'b0, b};
		o.f = r[64];
		o.v = r[64] ? '1 : r[63:0];
		return o;
	endfunction

	function automatic sat_t usub0(input logic [63:0] a, input logic [63:0] b);
		sat_t o;
		o.f = b > a;
		o.v = (b > a) ? '0 : a - b;
		return o;
	endfunction

	function automatic sat_t sadd(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		sat_t        o;
		r = a + b;
		o.f = (a[63] == b[63]) && (r[63] != a[63]);
		o.v = o.f ? (a[63] ? S64_MIN : S64_MAX) : r;
		return o;
	endfunction

	function automatic sat_t ssub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		sat_t        o;
		r = a - b;
		o.f = (a[63] != b[63]) && (r[63] != a[63]);
		o.v = o.f ? (a[63] ? S64_MIN : S64_MAX) : r;
		return o;
	endfunction

endpackage
`default_nettype wire

@@ sv/kcv_if.sv @@
// Measurement and estimate channel interfaces.
`default_nettype none
interface kcv_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] meas_x;
	logic signed [31:0] meas_y;
	modport source(output valid, meas_x, meas_y, input ready);
	modport sink(input valid, meas_x, meas_y, output ready);
endinterface

interface kcv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_pos_x;
	logic signed [31:0] est_vel_x;
	logic signed [31:0] est_pos_y;
	logic signed [31:0] est_vel_y;
	logic               saturated;
	modport source(output valid, est_pos_x, est_vel_x, est_pos_y, est_vel_y, saturated,
		input ready);
	modport sink(input valid, est_pos_x, est_vel_x, est_pos_y, est_vel_y, saturated,
		output ready);
endinterface
`default_nettype wire

@@ sv/kcv_mul.sv @@
// Multi-cycle 64x64 multiplier with rounding shift, signed magnitude handling and clamping.
`default_nettype none
module kcv_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic        sh32,
	input  wire logic        sgn,
	output logic             done,
	output logic [63:0]      res,
	output logic             ovf
);
	import kcv_pkg::*;

	localparam logic [127:0] RND32 = 128'd1 << 31;
	localparam logic [127:0] RND28 = 128'd1 << 27;

	logic [63:0]  a_q, b_q, ur_q, res_q, sres;
	logic [127:0] acc_q, pp_sh, rnd;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q, neg_q, sgn_q, sh32_q, uovf_q, ovf_q, sovf, rovf;
	logic [31:0]  ah, bh;
	logic [63:0]  pp, reff, ur_n;
	logic [6:0]   pp_shamt;

	assign ah       = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign bh       = cnt_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp       = ah * bh;
	assign pp_shamt = {cnt_q[0] & cnt_q[1], cnt_q[0] ^ cnt_q[1], 5'b0};
	assign pp_sh    = 128'(pp) << pp_shamt;
	assign rnd      = acc_q + (sh32_q ? RND32 : RND28);
	assign rovf     = sh32_q ? (|rnd[127:96]) : (|rnd[127:92]);
	assign ur_n     = sh32_q ? rnd[95:32] : rnd[91:28];

	always_comb begin
		reff = uovf_q ? '1 : ur_q;
		sres = reff;
		sovf = uovf_q;
		if (sgn_q) begin
			if (neg_q) begin
				if (reff > S64_MIN) begin
					sres = S64_MIN;
					sovf = 1'b1;
				end else if (reff == S64_MIN) begin
					sres = S64_MIN;
				end else begin
					sres = -reff;
				end
			end else if (reff > S64_MAX) begin
				sres = S64_MAX;
				sovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 3'd5);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= (sgn && a[63]) ? -a : a;
			b_q    <= b;
			neg_q  <= sgn && a[63];
			sgn_q  <= sgn;
			sh32_q <= sh32;
			acc_q  <= '0;
		end else if (busy_q) begin
			case (cnt_q)
				3'd0, 3'd1, 3'd2, 3'd3: acc_q <= acc_q + pp_sh;
				3'd4: begin
					ur_q   <= ur_n;
					uovf_q <= rovf;
				end
				3'd5: begin
					res_q <= sres;
					ovf_q <= sovf;
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign ovf  = ovf_q;
endmodule
`default_nettype wire

@@ sv/kcv_div.sv @@
// Restoring divider, one quotient bit per cycle, 128-bit dividend by 64-bit divisor.
`default_nettype none
module kcv_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] n,
	input  wire logic [63:0]  d,
	output logic              done,
	output logic [63:0]       q,
	output logic              big
);
	import kcv_pkg::*;

	logic [127:0] n_q;
	logic [63:0]  d_q, r_q, q_q, r2;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q, big_q, ge;

	assign r2 = {r_q[62:0], n_q[127]};
	assign ge = r_q[63] || (r2 >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 7'd127);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			r_q   <= '0;
			q_q   <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= {n_q[126:0], 1'b0};
			r_q   <= ge ? r2 - d_q : r2;
			q_q   <= {q_q[62:0], ge};
			big_q <= big_q | q_q[63];
		end
	end

	assign done = done_q;
	assign q    = q_q;
	assign big  = big_q;
endmodule
`default_nettype wire

@@ sv/kcv_ctrl.sv @@
// Sequencer that steps both axes through predict, gain and update.
`default_nettype none
module kcv_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	output logic               in_ready,
	output kcv_pkg::cmd_t      cmd,
	input  wire kcv_pkg::sts_t sts
);
	import kcv_pkg::*;

	state_t state_q, state_n;
	logic   ax_q, ax_n;
	op_t    op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			ax_q    <= ax_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		ax_n     = ax_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					op      = OP_LOAD;
					ax_n    = 1'b0;
					state_n = ST_M_XP;
				end
			end
			ST_M_XP: begin op = OP_M_XP; state_n = ST_W_XP; end
			ST_W_XP: if (sts.mul_done) begin op = OP_W_XP; state_n = ST_M_C1; end
			ST_M_C1: begin op = OP_M_C1; state_n = ST_W_C1; end
			ST_W_C1: if (sts.mul_done) begin op = OP_W_C1; state_n = ST_M_PP; end
			ST_M_PP: begin op = OP_M_PP; state_n = ST_W_PP; end
			ST_W_PP: if (sts.mul_done) begin op = OP_W_PP; state_n = ST_D_K0; end
			ST_D_K0: begin op = OP_D_K0; state_n = ST_W_K0; end
			ST_W_K0: if (sts.div_done) begin op = OP_W_K0; state_n = ST_D_K1; end
			ST_D_K1: begin op = OP_D_K1; state_n = ST_W_K1; end
			ST_W_K1: if (sts.div_done) begin op = OP_W_K1; state_n = ST_M_E0; end
			ST_M_E0: begin op = OP_M_E0; state_n = ST_W_POS; end
			ST_W_POS: if (sts.mul_done) begin op = OP_W_POS; state_n = ST_M_E1; end
			ST_M_E1: begin op = OP_M_E1; state_n = ST_W_VEL; end
			ST_W_VEL: if (sts.mul_done) begin op = OP_W_VEL; state_n = ST_M_CP; end
			ST_M_CP: begin op = OP_M_CP; state_n = ST_W_CP; end
			ST_W_CP: if (sts.mul_done) begin op = OP_W_CP; state_n = ST_M_CC; end
			ST_M_CC: begin op = OP_M_CC; state_n = ST_W_CC; end
			ST_W_CC: if (sts.mul_done) begin op = OP_W_CC; state_n = ST_M_CV; end
			ST_M_CV: begin op = OP_M_CV; state_n = ST_W_CV; end
			ST_W_CV: begin
				if (sts.mul_done) begin
					op = OP_W_CV;
					if (ax_q) begin
						state_n = ST_FIN;
					end else begin
						ax_n    = 1'b1;
						state_n = ST_M_XP;
					end
				end
			end
			ST_FIN: begin
				if (!sts.out_full) begin
					op      = OP_OUT;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign cmd.op = op;
	assign cmd.ax = ax_q;
endmodule
`default_nettype wire

@@ sv/kcv_dp.sv @@
// Datapath: configuration, track state, step temporaries, arithmetic units and result register.
`default_nettype none
module kcv_dp #(
	parameter int DATA_WIDTH = kcv_pkg::DATA_W_DEF,
	parameter int COV_WIDTH  = kcv_pkg::COV_W_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kcv_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [kcv_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire kcv_pkg::cmd_t                  cmd,
	output kcv_pkg::sts_t                       sts,
	input  wire logic signed [31:0]             meas_x,
	input  wire logic signed [31:0]             meas_y,
	output logic                                est_valid,
	input  wire logic                           est_ready,
	output logic signed [31:0]                  est_pos_x,
	output logic signed [31:0]                  est_vel_x,
	output logic signed [31:0]                  est_pos_y,
	output logic signed [31:0]                  est_vel_y,
	output logic                                saturated
);
	import kcv_pkg::*;

	localparam logic signed [63:0] DMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] DMIN = -DMAX - 64'sd1;
	localparam logic [63:0] CMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COV_WIDTH);
	localparam logic [63:0] ONE_RAW = 64'd1 << 40;
	localparam logic [63:0] ONE64 = (ONE_RAW > CMAX) ? CMAX : ONE_RAW;
	localparam logic [COV_WIDTH-1:0] COV_ONE = ONE64[COV_WIDTH-1:0];
	localparam logic signed [63:0] O_MAX = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] O_MIN = -64'sh8000_0000;

	function automatic sat_t dclamp(input logic signed [63:0] v);
		sat_t o;
		o.f = 1'b0;
		o.v = v;
		if (v > DMAX) begin
			o.f = 1'b1;
			o.v = DMAX;
		end else if (v < DMIN) begin
			o.f = 1'b1;
			o.v = DMIN;
		end
		return o;
	endfunction

	function automatic sat_t ocl(input logic signed [63:0] v);
		sat_t o;
		o.f = 1'b0;
		o.v = v;
		if (v > O_MAX) begin
			o.f = 1'b1;
			o.v = O_MAX;
		end else if (v < O_MIN) begin
			o.f = 1'b1;
			o.v = O_MIN;
		end
		return o;
	endfunction

	function automatic sat_t ucl(input logic [63:0] v);
		sat_t o;
		o.f = v > CMAX;
		o.v = (v > CMAX) ? CMAX : v;
		return o;
	endfunction

	logic [31:0]        time_step_q;
	logic [46:0]        pn_pos_q, pn_cross_q, pn_vel_q, mn_x_q, mn_y_q;
	logic signed [31:0] sv_x_q, sv_y_q, in_x_q, in_y_q;

	logic                         started_q, flag_q, fl_n;
	logic signed [DATA_WIDTH-1:0] tpos_q [2];
	logic signed [DATA_WIDTH-1:0] tvel_q [2];
	logic [COV_WIDTH-1:0]         cp_q [2];
	logic [COV_WIDTH-1:0]         cc_q [2];
	logic [COV_WIDTH-1:0]         cv_q [2];

	logic [63:0] xp_q, c1_q, ptp_q, ptc_q, ptv_q, s_q, k0_q, k1_q, e_q;
	logic [63:0] npos_q, nvel_q, ncp_q, ncc_q;

	logic               out_valid_q, out_sat_q;
	logic signed [31:0] o_px_q, o_vx_q, o_py_q, o_vy_q;

	logic signed [63:0] pos64, vel64, z64, sv64x, sv64y, opx64, ovx64, opy64, ovy64;
	logic [63:0]        p64, c64, v64, dt64, rn64;

	logic         mul_start, mul_sh32, mul_sgn, mul_done, mul_ovf;
	logic [63:0]  mul_a, mul_b, mres;
	logic         div_start, div_done, div_big;
	logic [127:0] div_n;
	logic [63:0]  div_d, div_q;

	sat_t t_xpa, t_xp, t_c1, t_c2, t_ptc, t_cc, t_p1, t_p2, t_ptp, t_v1, t_ptv, t_s;
	sat_t t_zc, t_e, t_npa, t_np, t_nva, t_nv, t_cp, t_ccn, t_cv, t_sv0, t_sv1;
	sat_t t_o0, t_o1, t_o2, t_o3;

	assign pos64 = 64'(tpos_q[cmd.ax]);
	assign vel64 = 64'(tvel_q[cmd.ax]);
	assign p64   = 64'(cp_q[cmd.ax]);
	assign c64   = 64'(cc_q[cmd.ax]);
	assign v64   = 64'(cv_q[cmd.ax]);
	assign dt64  = 64'(time_step_q);
	assign rn64  = cmd.ax ? 64'(mn_y_q) : 64'(mn_x_q);
	assign z64   = 64'(cmd.ax ? in_y_q : in_x_q);
	assign sv64x = 64'(sv_x_q);
	assign sv64y = 64'(sv_y_q);
	assign opx64 = 64'(tpos_q[0]);
	assign ovx64 = 64'(tvel_q[0]);
	assign opy64 = 64'(tpos_q[1]);
	assign ovy64 = 64'(tvel_q[1]);

	assign t_xpa = sadd(pos64, mres);
	assign t_xp  = dclamp(t_xpa.v);
	assign t_c1  = usadd(c64, mres);
	assign t_c2  = usadd(t_c1.v, 64'(pn_cross_q));
	assign t_ptc = ucl(t_c2.v);
	assign t_cc  = usadd(c64, c1_q);
	assign t_p1  = usadd(p64, mres);
	assign t_p2  = usadd(t_p1.v, 64'(pn_pos_q));
	assign t_ptp = ucl(t_p2.v);
	assign t_v1  = usadd(v64, 64'(pn_vel_q));
	assign t_ptv = ucl(t_v1.v);
	assign t_s   = usadd(ptp_q, rn64);
	assign t_zc  = dclamp(z64);
	assign t_e   = ssub(t_zc.v, xp_q);
	assign t_npa = sadd(xp_q, mres);
	assign t_np  = dclamp(t_npa.v);
	assign t_nva = sadd(vel64, mres);
	assign t_nv  = dclamp(t_nva.v);
	assign t_cp  = usub0(ptp_q, mres);
	assign t_ccn = usub0(ptc_q, mres);
	assign t_cv  = usub0(ptv_q, mres);
	assign t_sv0 = dclamp(sv64x);
	assign t_sv1 = dclamp(sv64y);
	assign t_o0  = ocl(opx64);
	assign t_o1  = ocl(ovx64);
	assign t_o2  = ocl(opy64);
	assign t_o3  = ocl(ovy64);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		mul_sh32  = 1'b0;
		mul_sgn   = 1'b0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (cmd.op)
			OP_M_XP: begin mul_start = 1'b1; mul_a = vel64; mul_b = dt64; mul_sgn = 1'b1; end
			OP_M_C1: begin mul_start = 1'b1; mul_a = v64; mul_b = dt64; end
			OP_M_PP: begin mul_start = 1'b1; mul_a = t_cc.v; mul_b = dt64; end
			OP_M_E0: begin
				mul_start = 1'b1; mul_a = t_e.v; mul_b = k0_q; mul_sh32 = 1'b1; mul_sgn = 1'b1;
			end
			OP_M_E1: begin
				mul_start = 1'b1; mul_a = e_q; mul_b = k1_q; mul_sh32 = 1'b1; mul_sgn = 1'b1;
			end
			OP_M_CP: begin mul_start = 1'b1; mul_a = k0_q; mul_b = ptp_q; mul_sh32 = 1'b1; end
			OP_M_CC: begin mul_start = 1'b1; mul_a = k0_q; mul_b = ptc_q; mul_sh32 = 1'b1; end
			OP_M_CV: begin mul_start = 1'b1; mul_a = k1_q; mul_b = ptc_q; mul_sh32 = 1'b1; end
			OP_D_K0: begin div_start = 1'b1; div_n = {32'b0, ptp_q, 32'b0}; div_d = t_s.v; end
			OP_D_K1: begin div_start = 1'b1; div_n = {32'b0, ptc_q, 32'b0}; div_d = s_q; end
			default: ;
		endcase
	end

	always_comb begin
		fl_n = mul_done & mul_ovf;
		case (cmd.op)
			OP_LOAD: fl_n = !started_q && (t_sv0.f || t_sv1.f);
			OP_W_XP: fl_n = fl_n | t_xpa.f | t_xp.f;
			OP_W_C1: fl_n = fl_n | t_c1.f | t_c2.f | t_ptc.f;
			OP_M_PP: fl_n = fl_n | t_cc.f;
			OP_W_PP: fl_n = fl_n | t_p1.f | t_p2.f | t_ptp.f | t_v1.f | t_ptv.f;
			OP_D_K0: fl_n = fl_n | t_s.f;
			OP_W_K0, OP_W_K1: fl_n = fl_n | ((s_q != '0) && div_big);
			OP_M_E0: fl_n = fl_n | t_zc.f | t_e.f;
			OP_W_POS: fl_n = fl_n | t_npa.f | t_np.f;
			OP_W_VEL: fl_n = fl_n | t_nva.f | t_nv.f;
			OP_W_CP: fl_n = fl_n | t_cp.f;
			OP_W_CC: fl_n = fl_n | t_ccn.f;
			OP_W_CV: fl_n = fl_n | t_cv.f;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= RST_TIME_STEP;
			pn_pos_q    <= RST_PN_POS;
			pn_cross_q  <= RST_PN_CROSS;
			pn_vel_q    <= RST_PN_VEL;
			mn_x_q      <= RST_MN_X;
			mn_y_q      <= RST_MN_Y;
			sv_x_q      <= RST_START_VEL_X;
			sv_y_q      <= RST_START_VEL_Y;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TIME_STEP:   time_step_q <= cfg_wdata[31:0];
				CFG_PN_POS:      pn_pos_q    <= cfg_wdata;
				CFG_PN_CROSS:    pn_cross_q  <= cfg_wdata;
				CFG_PN_VEL:      pn_vel_q    <= cfg_wdata;
				CFG_MN_X:        mn_x_q      <= cfg_wdata;
				CFG_MN_Y:        mn_y_q      <= cfg_wdata;
				CFG_START_VEL_X: sv_x_q      <= cfg_wdata[31:0];
				CFG_START_VEL_Y: sv_y_q      <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				tpos_q[i] <= '0;
				tvel_q[i] <= '0;
				cp_q[i]   <= COV_ONE;
				cc_q[i]   <= '0;
				cv_q[i]   <= COV_ONE;
			end
		end else begin
			flag_q <= ((cmd.op == OP_LOAD) ? 1'b0 : flag_q) | fl_n;
			if (out_valid_q && est_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					if (!started_q) begin
						started_q <= 1'b1;
						tpos_q[0] <= '0;
						tpos_q[1] <= '0;
						tvel_q[0] <= t_sv0.v[DATA_WIDTH-1:0];
						tvel_q[1] <= t_sv1.v[DATA_WIDTH-1:0];
					end
				end
				OP_W_CV: begin
					tpos_q[cmd.ax] <= npos_q[DATA_WIDTH-1:0];
					tvel_q[cmd.ax] <= nvel_q[DATA_WIDTH-1:0];
					cp_q[cmd.ax]   <= ncp_q[COV_WIDTH-1:0];
					cc_q[cmd.ax]   <= ncc_q[COV_WIDTH-1:0];
					cv_q[cmd.ax]   <= t_cv.v[COV_WIDTH-1:0];
				end
				OP_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				in_x_q <= meas_x;
				in_y_q <= meas_y;
			end
			OP_W_XP: xp_q <= t_xp.v;
			OP_W_C1: begin
				c1_q  <= t_c1.v;
				ptc_q <= t_ptc.v;
			end
			OP_W_PP: begin
				ptp_q <= t_ptp.v;
				ptv_q <= t_ptv.v;
			end
			OP_D_K0: s_q <= t_s.v;
			OP_W_K0: k0_q <= (s_q == '0) ? '0 : div_q;
			OP_W_K1: k1_q <= (s_q == '0) ? '0 : div_q;
			OP_M_E0: e_q <= t_e.v;
			OP_W_POS: npos_q <= t_np.v;
			OP_W_VEL: nvel_q <= t_nv.v;
			OP_W_CP: ncp_q <= t_cp.v;
			OP_W_CC: ncc_q <= t_ccn.v;
			OP_OUT: begin
				o_px_q    <= t_o0.v[31:0];
				o_vx_q    <= t_o1.v[31:0];
				o_py_q    <= t_o2.v[31:0];
				o_vy_q    <= t_o3.v[31:0];
				out_sat_q <= flag_q | t_o0.f | t_o1.f | t_o2.f | t_o3.f;
			end
			default: ;
		endcase
	end

	kcv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh32   (mul_sh32),
		.sgn    (mul_sgn),
		.done   (mul_done),
		.res    (mres),
		.ovf    (mul_ovf)
	);

	kcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.q      (div_q),
		.big    (div_big)
	);

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.out_full = out_valid_q;

	assign est_valid = out_valid_q;
	assign est_pos_x = o_px_q;
	assign est_vel_x = o_vx_q;
	assign est_pos_y = o_py_q;
	assign est_vel_y = o_vy_q;
	assign saturated = out_sat_q;
endmodule
`default_nettype wire

@@ sv/kalman_cv_2d_tracker.sv @@
// Top level of the two-axis constant-velocity Kalman tracker.
//
//   channel | direction | payload                                     | transfer
//   meas    | in        | meas_x, meas_y                              | valid & ready
//   est     | out       | est_pos_x, est_vel_x, est_pos_y, est_vel_y, | valid & ready
//           |           | saturated                                   |
//   cfg     | in        | cfg_idx, cfg_wdata                          | cfg_we
//
// One measurement is processed at a time. Each axis uses eight passes through the shared
// multiplier and two 128-step gain divisions; the divisions take most of the processing time.
// A new measurement is taken while the previous result still waits in the output register.
// Reset restores the register defaults, zero track and identity covariance.
`default_nettype none
module kalman_cv_2d_tracker #(
	parameter int DATA_WIDTH = kcv_pkg::DATA_W_DEF,
	parameter int COV_WIDTH  = kcv_pkg::COV_W_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kcv_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [kcv_pkg::CFG_DATA_W-1:0] cfg_wdata,
	kcv_in_if.sink                              meas,
	kcv_out_if.source                           est
);
	import kcv_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign meas.ready = in_ready;

	kcv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (meas.valid && in_ready),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	kcv_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.COV_WIDTH  (COV_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.meas_x    (meas.meas_x),
		.meas_y    (meas.meas_y),
		.est_valid (est.valid),
		.est_ready (est.ready),
		.est_pos_x (est.est_pos_x),
		.est_vel_x (est.est_vel_x),
		.est_pos_y (est.est_pos_y),
		.est_vel_y (est.est_vel_y),
		.saturated (est.saturated)
	);
endmodule
`default_nettype wire

@@ sv/kcv_chk.sv @@
// Port-level checker for the tracker, attached by bind.
`default_nettype none
module kcv_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_pos_x,
	input wire logic        out_sat
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_sat))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second measurement taken while one is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after a measurement transfer");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");
endmodule

bind kalman_cv_2d_tracker kcv_chk u_kcv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (meas.valid),
	.in_ready  (meas.ready),
	.out_valid (est.valid),
	.out_ready (est.ready),
	.out_pos_x (est.est_pos_x),
	.out_sat   (est.saturated)
);
`default_nettype wire
